>>> rtl/core/s5ext_pkg.sv
`default_nettype none
package s5ext_pkg;

   typedef logic [7:0] aml_byte_type;
   typedef logic [2:0] sleep_type_type;

   // a candidate reaches from two bytes before the name to fifteen bytes after its start
   localparam int CAND_SPAN = 18;

   typedef logic [CAND_SPAN-1:0][7:0] cand_bytes_type;

   typedef struct packed {
      logic           hit;
      sleep_type_type type_a;
      sleep_type_type type_b;
   } cand_result_type;

   localparam aml_byte_type NAME_OP         = 8'h08;
   localparam aml_byte_type CHAR_BACKSLASH  = 8'h5C;
   localparam aml_byte_type CHAR_CARET      = 8'h5E;
   localparam aml_byte_type CHAR_UNDERSCORE = 8'h5F;
   localparam aml_byte_type CHAR_S          = 8'h53;
   localparam aml_byte_type CHAR_FIVE       = 8'h35;
   localparam aml_byte_type PACKAGE_OP      = 8'h12;
   localparam aml_byte_type VAR_PACKAGE_OP  = 8'h13;
   localparam aml_byte_type BYTE_PREFIX     = 8'h0A;
   localparam aml_byte_type WORD_PREFIX     = 8'h0B;

   // byte at offset off from the name start, zero outside the span
   function automatic aml_byte_type cand_byte(input cand_bytes_type b, input logic [4:0] off);
      logic [5:0] idx;
      idx = {1'b0, off} + 6'd2;
      if (idx < 6'(CAND_SPAN)) begin
         return b[idx[4:0]];
      end else begin
         return 8'h00;
      end
   endfunction

   // top: offset of the newest byte; room: bytes from the name start to the end of stream
   function automatic cand_result_type check_candidate(input cand_bytes_type b,
                                                       input logic [4:0] top,
                                                       input logic [33:0] room);
      cand_result_type r;
      logic            ok;
      aml_byte_type    lead;
      aml_byte_type    op;
      aml_byte_type    vb;
      aml_byte_type    cnt;
      aml_byte_type    pre;
      logic [1:0]      follow;
      logic [27:0]     plen;
      logic [4:0]      c;
      logic [29:0]     pend;
      sleep_type_type  val;
      r   = '0;
      ok  = 1'b1;
      val = '0;
      // opcode and lead length byte must lie inside the stream
      if (top < 5'd5) begin
         ok = 1'b0;
      end
      if (cand_byte(b, 5'd0) != CHAR_UNDERSCORE || cand_byte(b, 5'd1) != CHAR_S ||
          cand_byte(b, 5'd2) != CHAR_FIVE || cand_byte(b, 5'd3) != CHAR_UNDERSCORE) begin
         ok = 1'b0;
      end
      pre = b[1];
      if (!(pre == NAME_OP ||
            (b[0] == NAME_OP && (pre == CHAR_BACKSLASH || pre == CHAR_CARET)))) begin
         ok = 1'b0;
      end
      op = cand_byte(b, 5'd4);
      if (op != PACKAGE_OP && op != VAR_PACKAGE_OP) begin
         ok = 1'b0;
      end
      lead   = cand_byte(b, 5'd5);
      follow = lead[7:6];
      plen   = (follow == 2'd0) ? 28'(lead[5:0]) : 28'(lead[3:0]);
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < follow) begin
            if (5'(6 + i) > top) begin
               ok = 1'b0;
            end
            plen = plen | (28'(cand_byte(b, 5'(6 + i))) << (4 + 8 * i));
         end
      end
      c = 5'd6 + 5'(follow);
      if (plen == 28'd0) begin
         ok = 1'b0;
      end
      pend = 30'(c) + 30'(plen);
      if ({4'b0000, pend} > room) begin
         ok = 1'b0;
      end
      cnt = cand_byte(b, c);
      if (cnt < 8'd2) begin
         ok = 1'b0;
      end
      c = c + 5'd1;
      for (int n = 0; n < 2; n++) begin
         if (30'(c) >= pend) begin
            ok = 1'b0;
         end
         op = cand_byte(b, c);
         c  = c + 5'd1;
         vb = cand_byte(b, c);
         val = vb[2:0];
         if (op == BYTE_PREFIX) begin
            if (30'(c) >= pend) begin
               ok = 1'b0;
            end
            c = c + 5'd1;
         end else if (op == WORD_PREFIX) begin
            if (30'(c) + 30'd2 > pend) begin
               ok = 1'b0;
            end
            c = c + 5'd2;
         end else begin
            ok = 1'b0;
         end
         if (n == 0) begin
            r.type_a = val;
         end else begin
            r.type_b = val;
         end
      end
      r.hit = ok;
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/s5ext_if.sv
`default_nettype none
interface s5ext_req_if;
   logic                    valid;
   logic                    ready;
   s5ext_pkg::aml_byte_type aml_byte;
   logic                    first_byte;

   modport source (output valid, output aml_byte, output first_byte, input ready);
   modport sink (input valid, input aml_byte, input first_byte, output ready);
endinterface

interface s5ext_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      found;
   s5ext_pkg::sleep_type_type sleep_type_a;
   s5ext_pkg::sleep_type_type sleep_type_b;

   modport source (output valid, output found, output sleep_type_a, output sleep_type_b,
                   input ready);
   modport sink (input valid, input found, input sleep_type_a, input sleep_type_b,
                 output ready);
endinterface
`default_nettype wire

>>> rtl/core/aml_s5_sleep_type_extractor_core.sv
`default_nettype none
// Scans an AML body streamed one byte per request for the first _S5_ name object (NameOp,
// optionally with a root or parent prefix) holding a package of at least two byte/word
// integers, and returns one response on the last byte of the stream (csr_stream_length
// bytes) with found and both sleep types masked to 3 bits. One byte is taken every cycle
// with ready high; the response is registered out of stage s1. Each byte shifts a window of
// WINDOW_BYTES bytes, and one candidate start is checked per byte by a fixed checker lane;
// on the last byte all remaining starts are checked at once in parallel lanes, lowest start
// first. A request carrying first_byte restarts the search. Bytes beyond the stream length
// are taken and dropped. Ready drops only while a response is held and another last byte
// waits behind it. The stream length must be written while no request is in flight.
module aml_s5_sleep_type_extractor_core #(
   parameter int WINDOW_BYTES = 18
) (
   input  wire logic        clock,
   input  wire logic        reset,
   s5ext_req_if.sink        req_if,
   s5ext_rsp_if.source      rsp_if,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

   localparam int LOOKAHEAD  = WINDOW_BYTES - 3;
   localparam int FIRST_LANE = 3;

   logic [31:0]                    csr_stream_length_ff;
   s5ext_pkg::aml_byte_type        window_ff [WINDOW_BYTES];
   s5ext_pkg::aml_byte_type        window_in [WINDOW_BYTES];
   logic [31:0]                    byte_position_ff, byte_position_in;
   logic                           match_latched_ff, match_latched_in;
   s5ext_pkg::sleep_type_type      latched_type_a_ff, latched_type_a_in;
   s5ext_pkg::sleep_type_type      latched_type_b_ff, latched_type_b_in;
   logic                           s1_valid_ff, s1_valid_in;
   logic                           s1_last_ff, s1_last_in;
   logic [31:0]                    s1_rem_ff, s1_rem_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_found_ff, rsp_found_in;
   s5ext_pkg::sleep_type_type      rsp_type_a_ff, rsp_type_a_in;
   s5ext_pkg::sleep_type_type      rsp_type_b_ff, rsp_type_b_in;

   logic                           out_free, s1_move, req_take, in_range;
   logic [31:0]                    pos_cur;
   s5ext_pkg::cand_result_type     lane_res [FIRST_LANE:LOOKAHEAD];
   logic [LOOKAHEAD:FIRST_LANE]    lane_hit;
   s5ext_pkg::cand_result_type     sel;

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign s1_move      = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_if.ready = !s1_valid_ff || s1_move;
   assign req_take     = req_if.valid && req_if.ready;

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.found        = rsp_found_ff;
   assign rsp_if.sleep_type_a = rsp_type_a_ff;
   assign rsp_if.sleep_type_b = rsp_type_b_ff;

   // checker lanes, lane k looks at the start k bytes behind the newest byte
   for (genvar k = FIRST_LANE; k <= LOOKAHEAD; k++) begin : g_lane
      s5ext_pkg::cand_bytes_type cb;
      for (genvar j = 0; j < s5ext_pkg::CAND_SPAN; j++) begin : g_byte
         if (k + 2 - j >= 0) begin : g_in
            assign cb[j] = window_ff[k + 2 - j];
         end else begin : g_zero
            assign cb[j] = 8'h00;
         end
      end
      assign lane_res[k] = s5ext_pkg::check_candidate(cb, 5'(k),
                                                      {2'b00, s1_rem_ff} + 34'(k + 1));
      if (k == LOOKAHEAD) begin : g_every
         assign lane_hit[k] = lane_res[k].hit;
      end else begin : g_tail
         assign lane_hit[k] = lane_res[k].hit && s1_last_ff;
      end
   end

   // lowest start wins
   always_comb begin
      sel = '0;
      for (int k = LOOKAHEAD; k >= FIRST_LANE; k--) begin
         if (!sel.hit && lane_hit[k]) begin
            sel = lane_res[k];
         end
      end
   end

   always_comb begin
      pos_cur  = (req_if.valid && req_if.first_byte) ? 32'd0 : byte_position_ff;
      in_range = pos_cur < csr_stream_length_ff;

      window_in         = window_ff;
      byte_position_in  = byte_position_ff;
      match_latched_in  = match_latched_ff;
      latched_type_a_in = latched_type_a_ff;
      latched_type_b_in = latched_type_b_ff;
      s1_valid_in       = s1_valid_ff;
      s1_last_in        = s1_last_ff;
      s1_rem_in         = s1_rem_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_if.ready;
      rsp_found_in      = rsp_found_ff;
      rsp_type_a_in     = rsp_type_a_ff;
      rsp_type_b_in     = rsp_type_b_ff;

      if (s1_move) begin
         s1_valid_in = 1'b0;
         if (!match_latched_ff && sel.hit) begin
            match_latched_in  = 1'b1;
            latched_type_a_in = sel.type_a;
            latched_type_b_in = sel.type_b;
         end
         if (s1_last_ff) begin
            rsp_valid_in = 1'b1;
            if (match_latched_ff) begin
               rsp_found_in  = 1'b1;
               rsp_type_a_in = latched_type_a_ff;
               rsp_type_b_in = latched_type_b_ff;
            end else begin
               rsp_found_in  = sel.hit;
               rsp_type_a_in = sel.hit ? sel.type_a : 3'd0;
               rsp_type_b_in = sel.hit ? sel.type_b : 3'd0;
            end
         end
      end

      if (req_take) begin
         if (req_if.first_byte) begin
            for (int i = 0; i < WINDOW_BYTES; i++) begin
               window_in[i] = 8'h00;
            end
            byte_position_in  = 32'd0;
            match_latched_in  = 1'b0;
            latched_type_a_in = 3'd0;
            latched_type_b_in = 3'd0;
         end
         if (in_range) begin
            for (int i = WINDOW_BYTES - 1; i > 0; i--) begin
               window_in[i] = req_if.first_byte ? 8'h00 : window_ff[i - 1];
            end
            window_in[0]     = req_if.aml_byte;
            byte_position_in = pos_cur + 32'd1;
            s1_valid_in      = 1'b1;
            s1_last_in       = (pos_cur + 32'd1) == csr_stream_length_ff;
            s1_rem_in        = csr_stream_length_ff - pos_cur - 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_stream_length_ff <= 32'd0;
         for (int i = 0; i < WINDOW_BYTES; i++) begin
            window_ff[i] <= 8'h00;
         end
         byte_position_ff  <= 32'd0;
         match_latched_ff  <= 1'b0;
         latched_type_a_ff <= 3'd0;
         latched_type_b_ff <= 3'd0;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            csr_stream_length_ff <= csr_wr_data;
         end
         window_ff         <= window_in;
         byte_position_ff  <= byte_position_in;
         match_latched_ff  <= match_latched_in;
         latched_type_a_ff <= latched_type_a_in;
         latched_type_b_ff <= latched_type_b_in;
         s1_valid_ff       <= s1_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff    <= s1_last_in;
      s1_rem_ff     <= s1_rem_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_type_a_ff <= rsp_type_a_in;
      rsp_type_b_ff <= rsp_type_b_in;
   end

endmodule
`default_nettype wire

>>> rtl/core/s5ext_checker.sv
`default_nettype none
module s5ext_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_found,
   input wire logic [2:0] rsp_type_a,
   input wire logic [2:0] rsp_type_b
);

   // a held response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_found, rsp_type_a, rsp_type_b}))
      else $error("response changed while stalled");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_type_a == 3'd0 && rsp_type_b == 3'd0)
      else $error("sleep types nonzero without a match");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response right after reset");

   // with no response held the request side never stalls
   a_free_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

endmodule

bind aml_s5_sleep_type_extractor_core s5ext_checker u_s5ext_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_found  (rsp_if.found),
   .rsp_type_a (rsp_if.sleep_type_a),
   .rsp_type_b (rsp_if.sleep_type_b)
);
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int WIN_BYTES     = 18;
   localparam int LOOKAHEAD     = WIN_BYTES - 3;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      s5ext_pkg::aml_byte_type data;
      logic                    first;
   } aml_item_type;

   typedef struct packed {
      logic                      found;
      s5ext_pkg::sleep_type_type type_a;
      s5ext_pkg::sleep_type_type type_b;
   } s5_result_type;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    csr_wr_en   = 1'b0;
   logic [31:0]             csr_wr_data = '0;
   logic                    drv_valid   = 1'b0;
   s5ext_pkg::aml_byte_type drv_byte    = '0;
   logic                    drv_first   = 1'b0;
   logic                    mon_ready   = 1'b0;

   s5ext_req_if req_if();
   s5ext_rsp_if rsp_if();

   assign req_if.valid      = drv_valid;
   assign req_if.aml_byte   = drv_byte;
   assign req_if.first_byte = drv_first;
   assign rsp_if.ready      = mon_ready;

   aml_s5_sleep_type_extractor_core #(
      .WINDOW_BYTES(WIN_BYTES)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   aml_item_type            bytes_to_send[$];
   s5_result_type           s5_results_due[$];
   s5ext_pkg::aml_byte_type stream_buf[$];
   s5ext_pkg::aml_byte_type s5_obj[$];
   int                      send_idle_pct  = 0;
   int                      recv_stall_pct = 0;
   int                      mismatches     = 0;
   int                      items_queued   = 0;

   // scanner copy of the block state
   s5ext_pkg::aml_byte_type   scan_window[WIN_BYTES];
   logic [31:0]               scan_pos     = '0;
   logic                      scan_matched = 1'b0;
   s5ext_pkg::sleep_type_type scan_type_a  = '0;
   s5ext_pkg::sleep_type_type scan_type_b  = '0;
   logic [31:0]               cfg_len      = '0;

   initial begin
      for (int i = 0; i < WIN_BYTES; i++) begin
         scan_window[i] = '0;
      end
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   function automatic s5ext_pkg::aml_byte_type byte_at(input longint unsigned newest,
                                                       input longint unsigned at);
      if (at > newest || newest - at >= WIN_BYTES) begin
         return 8'h00;
      end
      return scan_window[int'(newest - at)];
   endfunction

   function automatic bit take_integer(input longint unsigned newest,
                                       inout longint unsigned c,
                                       input longint unsigned pend,
                                       output logic [31:0] v);
      s5ext_pkg::aml_byte_type op;
      v = '0;
      if (c >= pend) return 1'b0;
      op = byte_at(newest, c);
      c++;
      if (op == s5ext_pkg::BYTE_PREFIX) begin
         if (c >= pend) return 1'b0;
         v = 32'(byte_at(newest, c));
         c++;
         return 1'b1;
      end
      if (op == s5ext_pkg::WORD_PREFIX) begin
         if (pend - c < 2) return 1'b0;
         v = {16'h0000, byte_at(newest, c + 1), byte_at(newest, c)};
         c += 2;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit s5_package_ok(input longint unsigned newest,
                                        input longint unsigned p,
                                        input longint unsigned len,
                                        output logic [31:0] ta,
                                        output logic [31:0] tb);
      longint unsigned         c;
      longint unsigned         plen;
      longint unsigned         pend;
      s5ext_pkg::aml_byte_type lead;
      s5ext_pkg::aml_byte_type op;
      s5ext_pkg::aml_byte_type b1;
      int                      follow_n;
      ta = '0;
      tb = '0;
      if (p + 4 > len) return 1'b0;
      if (byte_at(newest, p) != s5ext_pkg::CHAR_UNDERSCORE ||
          byte_at(newest, p + 1) != s5ext_pkg::CHAR_S ||
          byte_at(newest, p + 2) != s5ext_pkg::CHAR_FIVE ||
          byte_at(newest, p + 3) != s5ext_pkg::CHAR_UNDERSCORE) begin
         return 1'b0;
      end
      b1 = (p >= 1) ? byte_at(newest, p - 1) : 8'h00;
      if (!((p >= 1 && b1 == s5ext_pkg::NAME_OP) ||
            (p >= 2 && byte_at(newest, p - 2) == s5ext_pkg::NAME_OP &&
             (b1 == s5ext_pkg::CHAR_BACKSLASH || b1 == s5ext_pkg::CHAR_CARET)))) begin
         return 1'b0;
      end
      c = p + 4;
      if (c >= len) return 1'b0;
      op = byte_at(newest, c);
      if (op != s5ext_pkg::PACKAGE_OP && op != s5ext_pkg::VAR_PACKAGE_OP) return 1'b0;
      c++;
      if (c >= len) return 1'b0;
      lead = byte_at(newest, c);
      c++;
      follow_n = int'(lead[7:6]);
      plen = (follow_n == 0) ? 64'(lead[5:0]) : 64'(lead[3:0]);
      for (int i = 0; i < follow_n; i++) begin
         if (c >= len) return 1'b0;
         plen |= 64'(byte_at(newest, c)) << (4 + 8 * i);
         c++;
      end
      if (plen == 0) return 1'b0;
      pend = c + plen;
      if (pend > len) return 1'b0;
      if (c >= pend) return 1'b0;
      if (byte_at(newest, c) < 8'd2) return 1'b0;
      c++;
      if (!take_integer(newest, c, pend, ta)) return 1'b0;
      if (!take_integer(newest, c, pend, tb)) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void try_name_at(input longint unsigned newest,
                                       input longint unsigned p,
                                       input longint unsigned len);
      logic [31:0] ta;
      logic [31:0] tb;
      if (scan_matched) return;
      if (s5_package_ok(newest, p, len, ta, tb)) begin
         scan_matched = 1'b1;
         scan_type_a  = ta[2:0];
         scan_type_b  = tb[2:0];
      end
   endfunction

   // advance the scanner by one accepted request
   function automatic void scan_aml_byte(input s5ext_pkg::aml_byte_type b, input logic first);
      longint unsigned q;
      longint unsigned len;
      longint unsigned p;
      s5_result_type   res;
      if (first) begin
         for (int i = 0; i < WIN_BYTES; i++) begin
            scan_window[i] = '0;
         end
         scan_pos     = '0;
         scan_matched = 1'b0;
         scan_type_a  = '0;
         scan_type_b  = '0;
      end
      len = cfg_len;
      q   = scan_pos;
      if (q >= len) return;
      for (int i = WIN_BYTES - 1; i > 0; i--) begin
         scan_window[i] = scan_window[i-1];
      end
      scan_window[0] = b;
      scan_pos = 32'(q + 1);
      if (q + 1 != len) begin
         if (q >= LOOKAHEAD) try_name_at(q, q - LOOKAHEAD, len);
         return;
      end
      // last byte: sweep every start not yet checked
      p = (q >= LOOKAHEAD) ? q - LOOKAHEAD : 0;
      while (p + 4 <= len && !scan_matched) begin
         try_name_at(q, p, len);
         p++;
      end
      res.found  = scan_matched;
      res.type_a = scan_matched ? scan_type_a : '0;
      res.type_b = scan_matched ? scan_type_b : '0;
      s5_results_due.push_back(res);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else begin
         if (drv_valid && req_if.ready) begin
            scan_aml_byte(drv_byte, drv_first);
         end
         if (!drv_valid || req_if.ready) begin
            if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               drv_valid <= 1'b1;
               drv_byte  <= bytes_to_send[0].data;
               drv_first <= bytes_to_send[0].first;
               void'(bytes_to_send.pop_front());
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : response_monitor
      s5_result_type want;
      if (reset) begin
         mon_ready <= 1'b0;
      end else begin
         if (rsp_if.valid && mon_ready) begin
            if (s5_results_due.size() == 0) begin
               report_mismatch("response with no request awaiting one");
            end else begin
               want = s5_results_due.pop_front();
               if (rsp_if.found !== want.found) begin
                  report_mismatch($sformatf("found got %b want %b", rsp_if.found, want.found));
               end
               if (rsp_if.sleep_type_a !== want.type_a) begin
                  report_mismatch($sformatf("sleep_type_a got %0d want %0d",
                                            rsp_if.sleep_type_a, want.type_a));
               end
               if (rsp_if.sleep_type_b !== want.type_b) begin
                  report_mismatch($sformatf("sleep_type_b got %0d want %0d",
                                            rsp_if.sleep_type_b, want.type_b));
               end
            end
         end
         mon_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic push_byte(input s5ext_pkg::aml_byte_type b, input logic first);
      aml_item_type it;
      it.data  = b;
      it.first = first;
      bytes_to_send.push_back(it);
      items_queued++;
   endtask

   // block idle: nothing queued, nothing on the bus, nothing owed
   task automatic wait_drained();
      do @(negedge clock);
      while (bytes_to_send.size() != 0 || drv_valid || s5_results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_stream_length(input logic [31:0] v);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_len = v;
   endtask

   // name object with package, mostly well formed, sometimes with one defect
   task automatic build_s5_object();
      s5ext_pkg::aml_byte_type body[$];
      s5ext_pkg::aml_byte_type lead;
      int                      flaw;
      int                      bad_int;
      int                      plen;
      int                      follow_n;
      flaw    = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
      bad_int = (flaw == 5) ? $urandom_range(0, 1) : 2;
      s5_obj  = {};
      case ($urandom_range(0, 2))
         0: begin
            s5_obj.push_back(s5ext_pkg::NAME_OP);
         end
         1: begin
            s5_obj.push_back(s5ext_pkg::NAME_OP);
            s5_obj.push_back(s5ext_pkg::CHAR_BACKSLASH);
         end
         default: begin
            s5_obj.push_back(s5ext_pkg::NAME_OP);
            s5_obj.push_back(s5ext_pkg::CHAR_CARET);
         end
      endcase
      if (flaw == 1) s5_obj[$urandom_range(0, s5_obj.size() - 1)] = 8'($urandom);
      s5_obj.push_back(s5ext_pkg::CHAR_UNDERSCORE);
      s5_obj.push_back(s5ext_pkg::CHAR_S);
      s5_obj.push_back(s5ext_pkg::CHAR_FIVE);
      s5_obj.push_back(s5ext_pkg::CHAR_UNDERSCORE);
      if (flaw == 2) s5_obj[s5_obj.size() - 1 - $urandom_range(0, 3)] = 8'($urandom);
      if (flaw == 3) begin
         s5_obj.push_back(8'($urandom));
      end else begin
         s5_obj.push_back($urandom_range(0, 1) ? s5ext_pkg::PACKAGE_OP :
                                                 s5ext_pkg::VAR_PACKAGE_OP);
      end
      body.push_back((flaw == 4) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(2, 255)));
      for (int k = 0; k < 2; k++) begin
         if (k == bad_int) begin
            body.push_back(8'($urandom));
            body.push_back(8'($urandom));
         end else if ($urandom_range(0, 1)) begin
            body.push_back(s5ext_pkg::BYTE_PREFIX);
            body.push_back(8'($urandom));
         end else begin
            body.push_back(s5ext_pkg::WORD_PREFIX);
            body.push_back(8'($urandom));
            body.push_back(8'($urandom));
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
      end
      plen = body.size();
      if (flaw == 6) plen = plen - $urandom_range(1, 3);
      if (flaw == 7) plen = 0;
      if (flaw == 0 && $urandom_range(0, 4) == 0) plen = plen + $urandom_range(1, 80);
      follow_n = (plen > 63) ? $urandom_range(1, 3) :
                 ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
      if (follow_n == 0) begin
         lead = 8'(plen);
      end else begin
         // bits 5:4 of a multi-byte lead are don't-care
         lead = {2'(follow_n), 2'($urandom_range(0, 3)), 4'(plen)};
      end
      if (flaw == 8) lead = 8'($urandom);
      s5_obj.push_back(lead);
      for (int k = 0; k < follow_n; k++) begin
         s5_obj.push_back(8'(plen >> (4 + 8 * k)));
      end
      foreach (body[k]) s5_obj.push_back(body[k]);
   endtask

   task automatic send_stream(input int len, input bit partial);
      int n;
      int off;
      int restart_at;
      stream_buf = {};
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
               0: stream_buf.push_back(s5ext_pkg::NAME_OP);
               1: stream_buf.push_back(s5ext_pkg::CHAR_UNDERSCORE);
               2: stream_buf.push_back(s5ext_pkg::CHAR_S);
               3: stream_buf.push_back(s5ext_pkg::CHAR_FIVE);
               4: stream_buf.push_back(s5ext_pkg::PACKAGE_OP);
               default: stream_buf.push_back(s5ext_pkg::BYTE_PREFIX);
            endcase
         end else begin
            stream_buf.push_back(8'($urandom));
         end
      end
      if (len > 0) begin
         repeat (($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 2)) begin
            build_s5_object();
            if (len > s5_obj.size() && $urandom_range(0, 2) != 0) begin
               off = $urandom_range(0, len - s5_obj.size());
            end else begin
               off = $urandom_range(0, len - 1);
            end
            foreach (s5_obj[k]) begin
               if (off + k < len) stream_buf[off + k] = s5_obj[k];
            end
         end
      end
      n = (partial && len > 0) ? $urandom_range(1, len) : len;
      // occasional restart in the middle of a stream
      restart_at = ($urandom_range(0, 9) == 0 && len > 1) ? $urandom_range(1, len - 1) : -1;
      for (int k = 0; k < n; k++) begin
         push_byte(stream_buf[k], (k == 0 || k == restart_at));
      end
      // bytes past the end are dropped
      if (!partial && $urandom_range(0, 6) == 0) begin
         repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
      end
   endtask

   initial begin : stimulus
      int len;
      int phase;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty stream: bytes dropped
      set_stream_length(32'd0);
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b0);
      // maximum length: never reaches the last byte
      set_stream_length(32'hFFFF_FFFF);
      push_byte(s5ext_pkg::NAME_OP, 1'b1);
      push_byte(s5ext_pkg::CHAR_UNDERSCORE, 1'b0);
      push_byte(s5ext_pkg::CHAR_S, 1'b0);
      push_byte(s5ext_pkg::CHAR_FIVE, 1'b0);
      push_byte(s5ext_pkg::CHAR_UNDERSCORE, 1'b0);
      push_byte(s5ext_pkg::PACKAGE_OP, 1'b0);
      // length dropped below position, then a short stream
      set_stream_length(32'd3);
      push_byte(8'h5A, 1'b0);
      push_byte(s5ext_pkg::CHAR_UNDERSCORE, 1'b1);
      push_byte(s5ext_pkg::CHAR_S, 1'b0);
      push_byte(s5ext_pkg::CHAR_FIVE, 1'b0);
      // well formed package, byte then word integer
      set_stream_length(32'd13);
      push_byte(s5ext_pkg::NAME_OP, 1'b1);
      push_byte(s5ext_pkg::CHAR_UNDERSCORE, 1'b0);
      push_byte(s5ext_pkg::CHAR_S, 1'b0);
      push_byte(s5ext_pkg::CHAR_FIVE, 1'b0);
      push_byte(s5ext_pkg::CHAR_UNDERSCORE, 1'b0);
      push_byte(s5ext_pkg::PACKAGE_OP, 1'b0);
      push_byte(8'h06, 1'b0);
      push_byte(8'h02, 1'b0);
      push_byte(s5ext_pkg::BYTE_PREFIX, 1'b0);
      push_byte(8'h05, 1'b0);
      push_byte(s5ext_pkg::WORD_PREFIX, 1'b0);
      push_byte(8'h06, 1'b0);
      push_byte(8'h01, 1'b0);

      phase = 0;
      while (items_queued < 600 && phase < 400) begin
         case ($urandom_range(0, 9))
            0: len = $urandom_range(0, 3);
            1, 2, 3, 4, 5, 6: len = $urandom_range(4, 24);
            7, 8: len = $urandom_range(25, 48);
            default: len = $urandom_range(49, 120);
         endcase
         set_stream_length(32'(len));
         case (phase % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 70;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 70;
            end
            default: begin
               send_idle_pct  = 20;
               recv_stall_pct = 20;
            end
         endcase
         // carry on the stream left from the previous setting
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
         end
         repeat ($urandom_range(2, 5)) send_stream(len, 1'b0);
         if ($urandom_range(0, 4) == 0) send_stream(len, 1'b1);
         phase++;
      end

      wait_drained();
      if (mismatches == 0) begin
         $display("aml_s5_sleep_type_extractor_core regression: pass");
      end else begin
         $display("aml_s5_sleep_type_extractor_core regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("aml_s5_sleep_type_extractor_core regression: fail");
      $finish;
   end

endmodule
